FILE: rtl/core/csvtok_pkg.sv
`default_nettype none

package csvtok_pkg;

	// Result item kinds
	localparam logic ITEM_VALUE = 1'b0;
	localparam logic ITEM_DONE  = 1'b1;

	// Token kinds
	localparam logic [2:0] K_DELIM   = 3'd0;
	localparam logic [2:0] K_STRING  = 3'd1;
	localparam logic [2:0] K_NUMBER  = 3'd2;
	localparam logic [2:0] K_COMMENT = 3'd3;
	localparam logic [2:0] K_LINE    = 3'd4;
	localparam logic [2:0] K_END     = 3'd5;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_CHAR   = 2'd1;
	localparam logic [1:0] ERR_STRING = 2'd2;
	localparam logic [1:0] ERR_RAGGED = 2'd3;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_LE    = 8'h65;

	// Widths of the result fields
	localparam int COL_OUT_W = 12;
	localparam int ROW_OUT_W = 20;
	localparam int WID_OUT_W = 13;
	localparam int NUM_W     = 32;
	localparam int TDATA_W   = 88;
	localparam int TUSER_W   = 4;

	// Result queue
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic                 item_kind;
		logic [2:0]           token_kind;
		logic [7:0]           value_char;
		logic [COL_OUT_W-1:0] column_index;
		logic [ROW_OUT_W-1:0] row_count;
		logic [WID_OUT_W-1:0] table_width;
		logic [NUM_W-1:0]     number_count;
		logic [1:0]           error_code;
		logic                 last_of_run;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/csv_stream_tokenizer_unit.sv
// A word taken is held in the input stage; its results enter the four-entry result
// queue once the queue has room for two results, and are offered from the queue.
// Throughput: one input word per cycle while the queue has room for two results; the
// output sends one result per transfer, so two results of one word go out in turn.
// Reset (arst_n low, asynchronous): lexer between tokens, all counters and the
// error cleared, input stage and result queue empty. No clearing pass follows.
`default_nettype none

module csv_stream_tokenizer_unit #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS    = 1048576
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [7:0] text_byte
	input  wire logic [7:0]                       s_axis_tdata,
	// [0] end_mark
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [7:0] value_char, [19:8] column_index, [39:20] row_count,
	// [52:40] table_width, [84:53] number_count, [86:85] error_code, [87] zero
	output logic [csvtok_pkg::TDATA_W-1:0]        m_axis_tdata,
	// [0] item_kind, [3:1] token_kind
	output logic [csvtok_pkg::TUSER_W-1:0]        m_axis_tuser,
	// last_of_run
	output logic                                  m_axis_tlast
);
	import csvtok_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int WID_W  = $clog2(MAX_COLUMNS + 1);
	localparam int PROD_W = WID_W + ROW_W;
	localparam int CMP_W  = (PROD_W > NUM_W) ? PROD_W : NUM_W;

	typedef enum logic [2:0] {M_IDLE, M_STR, M_STRQ, M_NUM, M_CMT} mode_t;

	// Table counters; prod tracks wid * row so the ragged check needs no multiplier.
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [WID_W-1:0]  wid;
		logic [PROD_W-1:0] prod;
	} cnt_t;

	function automatic cnt_t line_end(input cnt_t s);
		cnt_t r;
		r = s;
		if (s.col != '0) begin
			if (s.row == '0) begin
				r.wid  = WID_W'(s.col) + WID_W'(1);
				r.prod = PROD_W'(s.col) + PROD_W'(1);
			end else if (s.row < ROW_W'(MAX_ROWS - 1)) begin
				r.prod = s.prod + PROD_W'(s.wid);
			end
			if (s.row < ROW_W'(MAX_ROWS - 1)) begin
				r.row = s.row + ROW_W'(1);
			end
		end
		r.col = '0;
		return r;
	endfunction

	function automatic res_t mk(input logic kind, input logic [2:0] tok,
			input logic [7:0] chv, input cnt_t s, input logic [NUM_W-1:0] nv,
			input logic [1:0] ev);
		res_t r;
		r.item_kind    = kind;
		r.token_kind   = tok;
		r.value_char   = chv;
		r.column_index = COL_OUT_W'(s.col);
		r.row_count    = ROW_OUT_W'(s.row);
		r.table_width  = WID_OUT_W'(s.wid);
		r.number_count = nv;
		r.error_code   = ev;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       adv;

	// Lexer state
	mode_t            mode_q;
	cnt_t             cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [1:0]       err_q;

	// Next-state working values
	mode_t            m;
	cnt_t             cs;
	logic [NUM_W-1:0] num;
	logic [1:0]       err;
	logic             do_start;
	logic             e0_v;
	logic             e1_v;
	res_t             e0;
	res_t             e1;
	res_t             w0;
	res_t             w1;
	logic [1:0]       n_wr;

	// Result queue
	res_t           q_mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   qcnt_q;
	logic           pop;
	res_t           head;

	assign adv           = valid_s1 && (qcnt_q <= (QAW+1)'(QDEPTH - 2));
	assign s_axis_tready = !valid_s1 || adv;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	always_comb begin
		m        = mode_q;
		cs       = cnt_q;
		num      = num_q;
		err      = err_q;
		do_start = 1'b0;
		e0_v     = 1'b0;
		e1_v     = 1'b0;
		e0       = '0;
		e1       = '0;
		if (end_s1) begin
			case (m)
				M_STR: begin
					if (err == ERR_NONE) begin
						err = ERR_STRING;
					end
				end
				M_STRQ: begin
					e0_v = 1'b1;
					e0   = mk(ITEM_DONE, K_STRING, CH_NUL, cs, num, err);
				end
				M_NUM: begin
					if (num != '1) begin
						num = num + NUM_W'(1);
					end
					e0_v = 1'b1;
					e0   = mk(ITEM_DONE, K_NUMBER, CH_NUL, cs, num, err);
				end
				M_CMT: begin
					e0_v = 1'b1;
					e0   = mk(ITEM_DONE, K_COMMENT, CH_NUL, cs, num, err);
				end
				default: begin
				end
			endcase
			m  = M_IDLE;
			cs = line_end(cs);
			if (err == ERR_NONE && num != '0 && CMP_W'(num) != CMP_W'(cs.prod)) begin
				err = ERR_RAGGED;
			end
			e1_v = 1'b1;
			e1   = mk(ITEM_DONE, K_END, CH_NUL, cs, num, err);
		end else begin
			case (m)
				M_STR: begin
					if (char_s1 == CH_QUOTE) begin
						m = M_STRQ;
					end else begin
						e0_v = 1'b1;
						e0   = mk(ITEM_VALUE, K_STRING, char_s1, cs, num, err);
					end
				end
				M_STRQ: begin
					// A second quote is an escaped quote; anything else closes the string.
					e0_v = 1'b1;
					if (char_s1 == CH_QUOTE) begin
						m  = M_STR;
						e0 = mk(ITEM_VALUE, K_STRING, char_s1, cs, num, err);
					end else begin
						e0       = mk(ITEM_DONE, K_STRING, CH_NUL, cs, num, err);
						do_start = 1'b1;
					end
				end
				M_NUM: begin
					e0_v = 1'b1;
					if (char_s1 inside {[CH_0:CH_9], CH_DOT, CH_MINUS, CH_LE, CH_UE}) begin
						e0 = mk(ITEM_VALUE, K_NUMBER, char_s1, cs, num, err);
					end else begin
						if (num != '1) begin
							num = num + NUM_W'(1);
						end
						e0       = mk(ITEM_DONE, K_NUMBER, CH_NUL, cs, num, err);
						do_start = 1'b1;
					end
				end
				M_CMT: begin
					e0_v = 1'b1;
					if (char_s1 == CH_LF || char_s1 == CH_CR) begin
						e0       = mk(ITEM_DONE, K_COMMENT, CH_NUL, cs, num, err);
						do_start = 1'b1;
					end else begin
						e0 = mk(ITEM_VALUE, K_COMMENT, char_s1, cs, num, err);
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase
			if (do_start) begin
				m = M_IDLE;
				if (char_s1 inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF}) begin
					m = M_IDLE;
				end else if (char_s1 == CH_QUOTE) begin
					m = M_STR;
				end else if (char_s1 == CH_COMMA) begin
					if (cs.col < COL_W'(MAX_COLUMNS - 1)) begin
						cs.col = cs.col + COL_W'(1);
					end
					e1_v = 1'b1;
					e1   = mk(ITEM_DONE, K_DELIM, char_s1, cs, num, err);
				end else if (char_s1 inside {[CH_0:CH_9], CH_MINUS}) begin
					m    = M_NUM;
					e1_v = 1'b1;
					e1   = mk(ITEM_VALUE, K_NUMBER, char_s1, cs, num, err);
				end else if (char_s1 == CH_HASH) begin
					m    = M_CMT;
					e1_v = 1'b1;
					e1   = mk(ITEM_VALUE, K_COMMENT, char_s1, cs, num, err);
				end else if (char_s1 == CH_LF) begin
					cs   = line_end(cs);
					e1_v = 1'b1;
					e1   = mk(ITEM_DONE, K_LINE, char_s1, cs, num, err);
				end else if (err == ERR_NONE) begin
					err = ERR_CHAR;
				end
			end
		end

		// Compact the results so that the first one written is always w0.
		n_wr = {1'b0, e0_v} + {1'b0, e1_v};
		w0   = e0_v ? e0 : e1;
		w1   = e1;
		w0.last_of_run = (n_wr == 2'd1);
		w1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= '0;
			num_q  <= '0;
			err_q  <= ERR_NONE;
		end else if (adv) begin
			mode_q <= m;
			cnt_q  <= cs;
			num_q  <= num;
			err_q  <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_wr != 2'd0) begin
			q_mem[wr_q] <= w0;
		end
		if (adv && n_wr == 2'd2) begin
			q_mem[wr_q + QAW'(1)] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			qcnt_q <= '0;
		end else begin
			if (adv) begin
				wr_q <= wr_q + QAW'(n_wr);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			qcnt_q <= qcnt_q + (adv ? (QAW+1)'(n_wr) : '0) - (QAW+1)'(pop);
		end
	end

	assign head          = q_mem[rd_q];
	assign m_axis_tvalid = (qcnt_q != '0);
	assign m_axis_tdata  = {1'b0, head.error_code, head.number_count, head.table_width,
		head.row_count, head.column_index, head.value_char};
	assign m_axis_tuser  = {head.token_kind, head.item_kind};
	assign m_axis_tlast  = head.last_of_run;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= (QAW+1)'(QDEPTH))
		else $error("result queue overfilled");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ERR_NONE |=> $stable(err_q))
		else $error("sticky error changed");

	a_product: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q.prod == PROD_W'(cnt_q.wid) * PROD_W'(cnt_q.row))
		else $error("width times rows tracker out of step");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> qcnt_q <= (QAW+1)'(QDEPTH - 2))
		else $error("input stage advanced without room for two results");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import csvtok_pkg::*;

	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS    = 1048576;

	typedef enum logic [2:0] {
		LX_IDLE = 3'd0,
		LX_STR  = 3'd1,
		LX_STRQ = 3'd2,
		LX_NUM  = 3'd3,
		LX_CMT  = 3'd4
	} lex_mode_t;

	typedef struct {
		logic [7:0] ch;
		logic       eom;
		int         reps;
		bit         typed;
		res_t       word;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [7:0]           s_tdata = 8'h00;
	logic                 s_tuser = 1'b0;
	logic                 m_tready = 1'b0;
	wire                  s_tready;
	wire                  m_tvalid;
	wire  [TDATA_W-1:0]   m_tdata;
	wire  [TUSER_W-1:0]   m_tuser;
	wire                  m_tlast;

	// Tokenizer state as predicted from the words accepted so far.
	lex_mode_t            lex_mode = LX_IDLE;
	logic [11:0]          col_cnt = '0;
	logic [19:0]          row_cnt = '0;
	logic [12:0]          width_q = '0;
	logic [31:0]          num_cnt = '0;
	logic [1:0]           err_q = ERR_NONE;

	res_t                 step_words[$];
	res_t                 words_due[$];
	dir_row_t             dir_rows[$];
	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   productive_items = 0;
	int                   mismatches = 0;
	bit                   long_hold_req = 1'b0;
	int                   hold_left = 0;

	csv_stream_tokenizer_unit #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),
		.m_axis_tuser(m_tuser),
		.m_axis_tlast(m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic res_t cur_word(logic kind, logic [2:0] tok, logic [7:0] ch);
		res_t w;
		w.item_kind    = kind;
		w.token_kind   = tok;
		w.value_char   = ch;
		w.column_index = col_cnt;
		w.row_count    = row_cnt;
		w.table_width  = width_q;
		w.number_count = num_cnt;
		w.error_code   = err_q;
		w.last_of_run  = 1'b0;
		return w;
	endfunction

	function automatic res_t word_of(logic kind, logic [2:0] tok, logic [7:0] ch,
			logic [11:0] col, logic [19:0] rows, logic [12:0] wid, logic [31:0] nums,
			logic [1:0] err);
		res_t w;
		w.item_kind    = kind;
		w.token_kind   = tok;
		w.value_char   = ch;
		w.column_index = col;
		w.row_count    = rows;
		w.table_width  = wid;
		w.number_count = nums;
		w.error_code   = err;
		w.last_of_run  = 1'b1;
		return w;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	task automatic flag_error(input logic [1:0] code);
		if (err_q == ERR_NONE) begin
			err_q = code;
		end
	endtask

	task automatic close_line();
		if (col_cnt != 0) begin
			// Only the first delimited row fixes the width of the table.
			if (row_cnt == 0) begin
				width_q = {1'b0, col_cnt} + 13'd1;
			end
			if (row_cnt < MAX_ROWS - 1) begin
				row_cnt++;
			end
		end
		col_cnt = '0;
	endtask

	task automatic count_number();
		if (num_cnt != '1) begin
			num_cnt++;
		end
	endtask

	task automatic lex_begin(input logic [7:0] c);
		lex_mode = LX_IDLE;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF) begin
		end else if (c == CH_QUOTE) begin
			lex_mode = LX_STR;
		end else if (c == CH_COMMA) begin
			if (col_cnt < MAX_COLUMNS - 1) begin
				col_cnt++;
			end
			step_words.push_back(cur_word(ITEM_DONE, K_DELIM, c));
		end else if (is_digit(c) || c == CH_MINUS) begin
			lex_mode = LX_NUM;
			step_words.push_back(cur_word(ITEM_VALUE, K_NUMBER, c));
		end else if (c == CH_HASH) begin
			lex_mode = LX_CMT;
			step_words.push_back(cur_word(ITEM_VALUE, K_COMMENT, c));
		end else if (c == CH_LF) begin
			close_line();
			step_words.push_back(cur_word(ITEM_DONE, K_LINE, c));
		end else begin
			flag_error(ERR_CHAR);
		end
	endtask

	// Works out the result words that one accepted input word causes.
	task automatic lex_step(input logic [7:0] c, input logic eom);
		longint unsigned cells;
		res_t w;
		step_words.delete();
		if (eom) begin
			case (lex_mode)
				LX_STR: flag_error(ERR_STRING);
				LX_STRQ: step_words.push_back(cur_word(ITEM_DONE, K_STRING, CH_NUL));
				LX_NUM: begin
					count_number();
					step_words.push_back(cur_word(ITEM_DONE, K_NUMBER, CH_NUL));
				end
				LX_CMT: step_words.push_back(cur_word(ITEM_DONE, K_COMMENT, CH_NUL));
				default: ;
			endcase
			lex_mode = LX_IDLE;
			close_line();
			cells = longint'(width_q) * longint'(row_cnt);
			if (num_cnt != 0 && longint'(num_cnt) != cells) begin
				flag_error(ERR_RAGGED);
			end
			step_words.push_back(cur_word(ITEM_DONE, K_END, CH_NUL));
		end else begin
			case (lex_mode)
				LX_STR: begin
					if (c == CH_QUOTE) begin
						lex_mode = LX_STRQ;
					end else begin
						step_words.push_back(cur_word(ITEM_VALUE, K_STRING, c));
					end
				end
				LX_STRQ: begin
					if (c == CH_QUOTE) begin
						lex_mode = LX_STR;
						step_words.push_back(cur_word(ITEM_VALUE, K_STRING, c));
					end else begin
						step_words.push_back(cur_word(ITEM_DONE, K_STRING, CH_NUL));
						lex_begin(c);
					end
				end
				LX_NUM: begin
					if (is_digit(c) || c == CH_DOT || c == CH_MINUS || c == CH_LE ||
							c == CH_UE) begin
						step_words.push_back(cur_word(ITEM_VALUE, K_NUMBER, c));
					end else begin
						count_number();
						step_words.push_back(cur_word(ITEM_DONE, K_NUMBER, CH_NUL));
						lex_begin(c);
					end
				end
				LX_CMT: begin
					if (c == CH_LF || c == CH_CR) begin
						step_words.push_back(cur_word(ITEM_DONE, K_COMMENT, CH_NUL));
						lex_begin(c);
					end else begin
						step_words.push_back(cur_word(ITEM_VALUE, K_COMMENT, c));
					end
				end
				default: lex_begin(c);
			endcase
		end
		if (step_words.size() > 0) begin
			w = step_words[step_words.size() - 1];
			w.last_of_run = 1'b1;
			step_words[step_words.size() - 1] = w;
		end
	endtask

	// Offers one word and waits for it to be taken; called at a rising edge.
	task automatic push_char(input logic [7:0] c, input logic eom, input bit typed,
			input res_t tw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= eom;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		lex_step(c, eom);
		if (typed) begin
			words_due.push_back(tw);
		end else begin
			foreach (step_words[i]) begin
				words_due.push_back(step_words[i]);
			end
		end
		if (step_words.size() > 0) begin
			productive_items++;
		end
	endtask

	task automatic send(input logic [7:0] c, input logic eom);
		push_char(c, eom, 1'b0, '0);
	endtask

	task automatic add_row(input logic [7:0] c, input logic eom, input int reps);
		dir_row_t r;
		r.ch    = c;
		r.eom   = eom;
		r.reps  = reps;
		r.typed = 1'b0;
		r.word  = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_checked(input logic [7:0] c, input logic eom, input res_t w);
		dir_row_t r;
		r.ch    = c;
		r.eom   = eom;
		r.reps  = 1;
		r.typed = 1'b1;
		r.word  = w;
		dir_rows.push_back(r);
	endtask

	function automatic logic [7:0] number_char();
		int k;
		k = $urandom_range(0, 13);
		case (k)
			10: return CH_DOT;
			11: return CH_MINUS;
			12: return CH_LE;
			13: return CH_UE;
			default: return CH_0 + 8'(k);
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	// Mostly well-formed fields with random content; the rest is noise and
	// strings cut off by an end mark.
	task automatic send_random_field();
		int pick;
		int n;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		n = $urandom_range(0, 5);
		if (pick < 30) begin
			if ($urandom_range(0, 3) == 0) begin
				send(CH_MINUS, 1'b0);
			end else begin
				send(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
			end
			repeat (n) send(number_char(), 1'b0);
		end else if (pick < 48) begin
			send(CH_QUOTE, 1'b0);
			repeat (n) begin
				b = 8'($urandom_range(0, 255));
				send(b, 1'b0);
				if (b == CH_QUOTE) begin
					send(b, 1'b0);
				end
			end
			send(CH_QUOTE, 1'b0);
		end else if (pick < 56) begin
			send(CH_HASH, 1'b0);
			repeat (n) send(8'($urandom_range(0, 255)), 1'b0);
			send($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
		end else if (pick < 70) begin
			send(CH_COMMA, 1'b0);
		end else if (pick < 80) begin
			send(CH_LF, 1'b0);
		end else if (pick < 86) begin
			send(blank_char(), 1'b0);
		end else if (pick < 90) begin
			send(8'($urandom_range(0, 255)), 1'b1);
		end else if (pick < 93) begin
			send(CH_QUOTE, 1'b0);
			repeat (n) send(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
			send(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic take_word();
		res_t w;
		if (words_due.size() == 0) begin
			$display("%0t: result word with none expected, tdata %h tuser %h", $time,
				m_tdata, m_tuser);
			mismatches++;
		end else begin
			w = words_due.pop_front();
			check_field("item_kind", w.item_kind, m_tuser[0]);
			check_field("token_kind", w.token_kind, m_tuser[3:1]);
			check_field("value_char", w.value_char, m_tdata[7:0]);
			check_field("column_index", w.column_index, m_tdata[19:8]);
			check_field("row_count", w.row_count, m_tdata[39:20]);
			check_field("table_width", w.table_width, m_tdata[52:40]);
			check_field("number_count", w.number_count, m_tdata[84:53]);
			check_field("error_code", w.error_code, m_tdata[86:85]);
			check_field("pad bit", 0, m_tdata[87]);
			check_field("last_of_run", w.last_of_run, m_tlast);
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (m_tready && m_tvalid) begin
				take_word();
			end
			if (long_hold_req) begin
				hold_left = 400;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int target;
		// The first delimited row fixes the table width that later rows are held to.
		add_checked(CH_COMMA, 1'b0,
			word_of(ITEM_DONE, K_DELIM, CH_COMMA, 12'd1, 20'd0, 13'd0, 32'd0, ERR_NONE));
		add_row(CH_COMMA, 1'b0, 2);
		add_checked(CH_COMMA, 1'b0,
			word_of(ITEM_DONE, K_DELIM, CH_COMMA, 12'd4, 20'd0, 13'd0, 32'd0, ERR_NONE));
		add_checked(CH_LF, 1'b0,
			word_of(ITEM_DONE, K_LINE, CH_LF, 12'd0, 20'd1, 13'd5, 32'd0, ERR_NONE));
		add_checked(8'hA5, 1'b1,
			word_of(ITEM_DONE, K_END, CH_NUL, 12'd0, 20'd1, 13'd5, 32'd0, ERR_NONE));
		// Empty string, then a string holding byte FF and a doubled quote.
		add_row(CH_QUOTE, 1'b0, 1);
		add_row(CH_QUOTE, 1'b0, 1);
		add_row(CH_COMMA, 1'b0, 1);
		add_row(CH_QUOTE, 1'b0, 1);
		add_row(8'hFF, 1'b0, 1);
		add_row(CH_QUOTE, 1'b0, 1);
		add_row(CH_QUOTE, 1'b0, 1);
		add_row(CH_QUOTE, 1'b0, 1);
		// The closing quote is followed straight by the start of a number.
		add_row(CH_MINUS, 1'b0, 1);
		add_row(CH_9, 1'b0, 1);
		add_row(CH_LE, 1'b0, 1);
		add_row(CH_UE, 1'b0, 1);
		add_row(CH_DOT, 1'b0, 1);
		add_row(CH_TAB, 1'b0, 1);
		add_row(CH_HASH, 1'b0, 1);
		add_row(CH_NUL, 1'b0, 1);
		add_row(CH_CR, 1'b0, 1);
		add_row(CH_HASH, 1'b0, 1);
		add_row(CH_LF, 1'b0, 1);
		// An open string at the end of input; the error stays from here on.
		add_row(CH_QUOTE, 1'b0, 1);
		add_row(8'h78, 1'b0, 1);
		add_checked(8'h00, 1'b1,
			word_of(ITEM_DONE, K_END, CH_NUL, 12'd0, 20'd2, 13'd5, 32'd1, ERR_STRING));
		add_row(8'h01, 1'b0, 1);
		add_row(CH_0 + 8'd7, 1'b0, 1);
		add_row(8'h00, 1'b1, 1);

		send_idle_pct = 34;
		recv_idle_pct = 88;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			repeat (dir_rows[i].reps) begin
				push_char(dir_rows[i].ch, dir_rows[i].eom, dir_rows[i].typed,
					dir_rows[i].word);
			end
		end

		target = productive_items + 400;
		while (productive_items < target) send_random_field();

		send_idle_pct = 88;
		recv_idle_pct = 34;
		target = productive_items + 400;
		while (productive_items < target) send_random_field();

		// No idling; the long hold on the output lets the block fill up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_req = 1'b1;
		target = productive_items + 400;
		while (productive_items < target) send_random_field();
		s_tvalid <= 1'b0;

		while (words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
